// ----- rtl/ts_afp_pkg.sv -----
// shared types and constants for the transport stream adaptation field parser
package ts_afp_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned SHIFT_W   = 48;
   localparam int unsigned BASE_W    = 33;
   localparam int unsigned EXT_W     = 9;
   localparam int unsigned FULL_W    = 42;
   localparam int unsigned BASE_LSB  = 15;
   localparam int unsigned LAYOUT_W  = 4;
   localparam int unsigned RSP_DATA_W = 240;

   // flag bit positions in the flags byte
   localparam int unsigned FLAG_PCR_BIT    = 4;
   localparam int unsigned FLAG_OPCR_BIT   = 3;
   localparam int unsigned FLAG_SPLICE_BIT = 2;

   // 27 MHz clock = base * 300 + extension
   localparam logic [FULL_W-1:0] CLOCK_SCALE = FULL_W'(300);

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_SHORT   = 2'd1,
      STATUS_OVERRUN = 2'd2
   } status_type;

   // one finished field, before the clock products are formed
   typedef struct packed {
      status_type          status;
      logic [BYTE_W-1:0]   field_length;
      logic [BYTE_W-1:0]   flag_bits;
      logic [BASE_W-1:0]   pcr_base;
      logic [EXT_W-1:0]    pcr_extension;
      logic                pcr_nonzero;
      logic [BASE_W-1:0]   opcr_base;
      logic [EXT_W-1:0]    opcr_extension;
      logic [BYTE_W-1:0]   splice_countdown;
   } field_snap_type;

endpackage

// ----- rtl/ts_adaptation_field_parser_top.sv -----
// top level of the transport stream adaptation field parser
//
// takes one byte of a transport packet per item, starting at the adaptation
// field length byte (req_tuser high), and returns one result item when the
// field ends or the buffer ends (req_tlast high) first. an item is accepted
// in every cycle while the result side keeps up: the parser state updates on
// each accepted byte, a field snapshot register loads on the byte that ends
// a field, and the clock products (base * 300 + extension) are formed between
// the snapshot and the output register. req_tready drops only while both the
// snapshot and the output register hold a result and the output is not being
// emptied in the same cycle.
// bytes outside a field are taken and dropped; a new length byte restarts
// parsing and drops any unfinished field without a result.
module ts_adaptation_field_parser_top (
   input  logic         clock,
   input  logic         reset,
   // input items
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // field_start
   input  logic         req_tlast,   // buffer_end
   // result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // from bit 0 up: parse_status[1:0], field_length[9:2], flag_bits[17:10],
   // pcr_base[50:18], pcr_extension[59:51], pcr_full[101:60],
   // opcr_base[134:102], opcr_extension[143:135], opcr_full[185:144],
   // chosen_time[227:186], splice_countdown[235:228], zero pad[239:236]
   output logic [239:0] rsp_tdata
);
   import ts_afp_pkg::*;

   logic            item_take;
   logic            out_free;
   logic            snap_valid;
   field_snap_type  snap;
   logic [FULL_W-1:0] pcr_full, opcr_full, chosen;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // output register can take a new result when empty or draining
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // snapshot register can take a new item when it moves on or is empty
   assign req_tready = out_free || !snap_valid;
   assign item_take  = req_tvalid && req_tready;

   ts_afp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .item_take   (item_take),
      .data_byte   (req_tdata),
      .field_start (req_tuser),
      .buffer_end  (req_tlast),
      .snap_take   (out_free),
      .snap_valid  (snap_valid),
      .snap        (snap)
   );

   ts_afp_clock_mul u_pcr_mul (
      .base      (snap.pcr_base),
      .extension (snap.pcr_extension),
      .full      (pcr_full)
   );

   ts_afp_clock_mul u_opcr_mul (
      .base      (snap.opcr_base),
      .extension (snap.opcr_extension),
      .full      (opcr_full)
   );

   // pcr wins whenever it is nonzero, known from base and extension directly
   assign chosen = snap.pcr_nonzero ? pcr_full : opcr_full;

   always_comb begin
      rsp_data_in = {4'b0000,
                     snap.splice_countdown,
                     chosen,
                     opcr_full,
                     snap.opcr_extension,
                     snap.opcr_base,
                     pcr_full,
                     snap.pcr_extension,
                     snap.pcr_base,
                     snap.flag_bits,
                     snap.field_length,
                     snap.status};
   end

   always_comb begin
      if (out_free) begin
         rsp_valid_in = snap_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only when a finished field moves on
   always_ff @(posedge clock) begin
      if (out_free && snap_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/ts_afp_parser.sv -----
// byte-serial parser state and the registered snapshot of a finished field
module ts_afp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_take,
   input  logic [7:0]               data_byte,
   input  logic                     field_start,
   input  logic                     buffer_end,
   input  logic                     snap_take,
   output logic                     snap_valid,
   output ts_afp_pkg::field_snap_type snap
);
   import ts_afp_pkg::*;

   logic                  active_ff, active_in;
   logic [BYTE_W-1:0]     pos_ff, pos_in;
   logic [BYTE_W-1:0]     len_ff, len_in;
   logic [BYTE_W-1:0]     flags_ff, flags_in;
   logic [SHIFT_W-1:0]    pcr_shift_ff, pcr_shift_in;
   logic [SHIFT_W-1:0]    opcr_shift_ff, opcr_shift_in;
   logic [BYTE_W-1:0]     splice_ff, splice_in;
   logic                  snap_valid_ff, snap_valid_in;
   field_snap_type        snap_ff, snap_in;

   logic                  emit;
   status_type            emit_status;
   logic [LAYOUT_W-1:0]   opcr_first, splice_pos;
   logic [LAYOUT_W-1:0]   opcr_first_n, splice_pos_n, flagged_last_n;
   logic                  pcr_ok, opcr_ok, spl_ok;

   // layout of the flagged body from the flags already held
   always_comb begin
      opcr_first = LAYOUT_W'(2) + (flags_ff[FLAG_PCR_BIT] ? LAYOUT_W'(6) : '0);
      splice_pos = opcr_first + (flags_ff[FLAG_OPCR_BIT] ? LAYOUT_W'(6) : '0);
   end

   always_comb begin
      active_in     = active_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      flags_in      = flags_ff;
      pcr_shift_in  = pcr_shift_ff;
      opcr_shift_in = opcr_shift_ff;
      splice_in     = splice_ff;
      emit          = 1'b0;
      emit_status   = STATUS_OK;

      if (field_start) begin
         active_in     = 1'b1;
         pos_in        = '0;
         len_in        = data_byte;
         flags_in      = '0;
         pcr_shift_in  = '0;
         opcr_shift_in = '0;
         splice_in     = '0;
         if (data_byte == '0) begin
            emit = 1'b1;
         end else if (buffer_end) begin
            emit        = 1'b1;
            emit_status = STATUS_SHORT;
         end
      end else if (active_ff) begin
         pos_in = pos_ff + BYTE_W'(1);
         if (pos_in == BYTE_W'(1)) begin
            flags_in = data_byte;
         end else if (flags_ff[FLAG_PCR_BIT] && pos_in < BYTE_W'(8)) begin
            pcr_shift_in = {pcr_shift_ff[SHIFT_W-BYTE_W-1:0], data_byte};
         end else if (flags_ff[FLAG_OPCR_BIT] && pos_in >= BYTE_W'(opcr_first)
                      && pos_in < BYTE_W'(opcr_first) + BYTE_W'(6)) begin
            opcr_shift_in = {opcr_shift_ff[SHIFT_W-BYTE_W-1:0], data_byte};
         end else if (flags_ff[FLAG_SPLICE_BIT] && pos_in == BYTE_W'(splice_pos)) begin
            splice_in = data_byte;
         end
         if (pos_in >= len_ff) begin
            emit        = 1'b1;
            emit_status = (BYTE_W'(flagged_last_n) > len_ff) ? STATUS_OVERRUN : STATUS_OK;
         end else if (buffer_end) begin
            emit        = 1'b1;
            emit_status = STATUS_SHORT;
         end
      end
      if (emit) begin
         active_in = 1'b0;
      end
   end

   // layout again from the updated flags, for the emitted result
   always_comb begin
      opcr_first_n   = LAYOUT_W'(2) + (flags_in[FLAG_PCR_BIT] ? LAYOUT_W'(6) : '0);
      splice_pos_n   = opcr_first_n + (flags_in[FLAG_OPCR_BIT] ? LAYOUT_W'(6) : '0);
      flagged_last_n = splice_pos_n + (flags_in[FLAG_SPLICE_BIT] ? LAYOUT_W'(1) : '0)
                       - LAYOUT_W'(1);
      pcr_ok  = flags_in[FLAG_PCR_BIT] && pos_in >= BYTE_W'(7);
      opcr_ok = flags_in[FLAG_OPCR_BIT]
                && pos_in >= BYTE_W'(opcr_first_n) + BYTE_W'(5);
      spl_ok  = flags_in[FLAG_SPLICE_BIT] && pos_in >= BYTE_W'(splice_pos_n);
   end

   always_comb begin
      snap_in.status           = emit_status;
      snap_in.field_length     = len_in;
      snap_in.flag_bits        = flags_in;
      snap_in.pcr_base         = pcr_ok ? pcr_shift_in[BASE_LSB +: BASE_W] : '0;
      snap_in.pcr_extension    = pcr_ok ? pcr_shift_in[EXT_W-1:0] : '0;
      snap_in.pcr_nonzero      = pcr_ok && (pcr_shift_in[BASE_LSB +: BASE_W] != '0
                                 || pcr_shift_in[EXT_W-1:0] != '0);
      snap_in.opcr_base        = opcr_ok ? opcr_shift_in[BASE_LSB +: BASE_W] : '0;
      snap_in.opcr_extension   = opcr_ok ? opcr_shift_in[EXT_W-1:0] : '0;
      snap_in.splice_countdown = spl_ok ? splice_in : '0;
   end

   always_comb begin
      if (item_take) begin
         snap_valid_in = emit;
      end else begin
         snap_valid_in = snap_valid_ff && !snap_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         pos_ff        <= '0;
         len_ff        <= '0;
         flags_ff      <= '0;
         pcr_shift_ff  <= '0;
         opcr_shift_ff <= '0;
         splice_ff     <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         if (item_take) begin
            active_ff     <= active_in;
            pos_ff        <= pos_in;
            len_ff        <= len_in;
            flags_ff      <= flags_in;
            pcr_shift_ff  <= pcr_shift_in;
            opcr_shift_ff <= opcr_shift_in;
            splice_ff     <= splice_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && emit) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

// ----- rtl/ts_afp_clock_mul.sv -----
// 27 mhz clock value from a 33-bit base and a 9-bit extension
module ts_afp_clock_mul (
   input  logic [32:0] base,
   input  logic [8:0]  extension,
   output logic [41:0] full
);
   import ts_afp_pkg::*;

   assign full = FULL_W'(base) * CLOCK_SCALE + FULL_W'(extension);

endmodule

// ----- tb/ts_adaptation_field_parser_top_tb.sv -----
// self-checking testbench for the transport stream adaptation field parser
`timescale 1ns / 100ps

module ts_adaptation_field_parser_top_tb;
   import ts_afp_pkg::*;

   // one result item as it sits on rsp_tdata, highest field first
   typedef struct packed {
      logic [3:0]        pad;
      logic [BYTE_W-1:0] splice;
      logic [FULL_W-1:0] chosen;
      logic [FULL_W-1:0] opcr_full;
      logic [EXT_W-1:0]  opcr_xtn;
      logic [BASE_W-1:0] opcr_base;
      logic [FULL_W-1:0] pcr_full;
      logic [EXT_W-1:0]  pcr_xtn;
      logic [BASE_W-1:0] pcr_base;
      logic [BYTE_W-1:0] flags;
      logic [BYTE_W-1:0] length;
      status_type        status;
   } af_result_type;

   localparam int unsigned CLOCK_BYTES  = 6;     // bytes in a pcr or opcr
   localparam int unsigned PCR_FIRST    = 2;     // body position of the first pcr byte
   localparam int unsigned MAX_WAIT     = 8;     // longest random idle per item
   localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off in the pressure test
   localparam int unsigned STUCK_LIMIT  = 2000;  // cycles without any handshake
   localparam int unsigned DRAIN_CYCLES = 10;    // settling time after the last result

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;   // data_byte
   logic         req_tuser = 1'b0; // field_start
   logic         req_tlast = 1'b0; // buffer_end
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // from bit 0 up: status, length, flags, pcr base/ext/full, opcr base/ext/full,
   // chosen time, splice countdown, zero pad
   logic [239:0] rsp_tdata;

   // idling switches for the two sides, and the request for one long hold-off
   bit req_idle_on;
   bit rsp_idle_on;
   bit rsp_hold_request;

   af_result_type pending_fields[$];  // expected results, oldest first
   int unsigned   mismatches;
   int unsigned   stuck_cycles;

   // parser state as the block should hold it
   bit                 pa_active;
   logic [BYTE_W-1:0]  pa_pos;
   logic [BYTE_W-1:0]  pa_len;
   logic [BYTE_W-1:0]  pa_flags;
   logic [SHIFT_W-1:0] pa_pcr;
   logic [SHIFT_W-1:0] pa_opcr;
   logic [BYTE_W-1:0]  pa_splice;

   ts_adaptation_field_parser_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // field layout, positions counted from 1 at the flags byte
   // ------------------------------------------------------------------
   function automatic int unsigned opcr_start();
      return PCR_FIRST + (pa_flags[FLAG_PCR_BIT] ? CLOCK_BYTES : 0);
   endfunction

   function automatic int unsigned splice_slot();
      return opcr_start() + (pa_flags[FLAG_OPCR_BIT] ? CLOCK_BYTES : 0);
   endfunction

   // last position the flagged fields need
   function automatic int unsigned flagged_end();
      return splice_slot() + (pa_flags[FLAG_SPLICE_BIT] ? 1 : 0) - 1;
   endfunction

   // split a 6-byte clock into base and extension; the reserved bits drop out
   function automatic void decode_clock(input logic [SHIFT_W-1:0] shift, input bit ok,
                                        output logic [BASE_W-1:0] base,
                                        output logic [EXT_W-1:0] ext,
                                        output logic [FULL_W-1:0] full);
      logic [63:0] ticks;
      base  = ok ? shift[BASE_LSB +: BASE_W] : '0;
      ext   = ok ? shift[EXT_W-1:0] : '0;
      ticks = 64'(base) * 64'(CLOCK_SCALE) + 64'(ext);
      full  = ticks[FULL_W-1:0];
   endfunction

   // build the result for the field now ending; clocks not fully seen read as zero
   function automatic void close_field(input status_type st, output af_result_type res);
      int unsigned p;
      bit          pcr_ok;
      bit          opcr_ok;
      bit          splice_ok;
      p         = pa_pos;
      pcr_ok    = pa_flags[FLAG_PCR_BIT] && p >= PCR_FIRST + CLOCK_BYTES - 1;
      opcr_ok   = pa_flags[FLAG_OPCR_BIT] && p >= opcr_start() + CLOCK_BYTES - 1;
      splice_ok = pa_flags[FLAG_SPLICE_BIT] && p >= splice_slot();
      res        = '0;
      res.status = st;
      res.length = pa_len;
      res.flags  = pa_flags;
      decode_clock(pa_pcr, pcr_ok, res.pcr_base, res.pcr_xtn, res.pcr_full);
      decode_clock(pa_opcr, opcr_ok, res.opcr_base, res.opcr_xtn, res.opcr_full);
      res.chosen = (res.pcr_full != '0) ? res.pcr_full : res.opcr_full;
      res.splice = splice_ok ? pa_splice : '0;
      pa_active  = 1'b0;
   endfunction

   // feed one accepted byte to the parser; returns 1 when it finishes a field
   function automatic bit advance_parser(input logic [7:0] b, input bit start, input bit bend,
                                         output af_result_type res);
      int unsigned pos;
      int unsigned o;
      int unsigned s;
      res = '0;
      if (start) begin
         pa_active = 1'b1;
         pa_pos    = '0;
         pa_len    = b;
         pa_flags  = '0;
         pa_pcr    = '0;
         pa_opcr   = '0;
         pa_splice = '0;
         if (b == '0) begin
            close_field(STATUS_OK, res);
            return 1'b1;
         end
         if (bend) begin
            close_field(STATUS_SHORT, res);
            return 1'b1;
         end
         return 1'b0;
      end
      if (!pa_active) return 1'b0;
      pa_pos = pa_pos + 8'd1;
      pos    = pa_pos;
      o      = opcr_start();
      s      = splice_slot();
      if (pos == 1) begin
         pa_flags = b;
      end else if (pa_flags[FLAG_PCR_BIT] && pos >= PCR_FIRST
                   && pos < PCR_FIRST + CLOCK_BYTES) begin
         pa_pcr = {pa_pcr[SHIFT_W-BYTE_W-1:0], b};
      end else if (pa_flags[FLAG_OPCR_BIT] && pos >= o && pos < o + CLOCK_BYTES) begin
         pa_opcr = {pa_opcr[SHIFT_W-BYTE_W-1:0], b};
      end else if (pa_flags[FLAG_SPLICE_BIT] && pos == s) begin
         pa_splice = b;
      end
      if (pos >= pa_len) begin
         if (flagged_end() > pa_len) close_field(STATUS_OVERRUN, res);
         else close_field(STATUS_OK, res);
         return 1'b1;
      end
      if (bend) begin
         close_field(STATUS_SHORT, res);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // ------------------------------------------------------------------
   // scoreboard: predict on every accepted byte, compare every accepted result
   // results pass the snapshot and output registers after their byte, so push before pop is safe
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      af_result_type predicted;
      af_result_type wanted;
      af_result_type got;
      if (!reset && req_tvalid && req_tready) begin
         if (advance_parser(req_tdata, req_tuser, req_tlast, predicted))
            pending_fields.push_back(predicted);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = af_result_type'(rsp_tdata);
         if (pending_fields.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %0h", $time, rsp_tdata);
            mismatches++;
         end else begin
            wanted = pending_fields.pop_front();
            check_field("parse_status", 64'(wanted.status), 64'(got.status));
            check_field("field_length", 64'(wanted.length), 64'(got.length));
            check_field("flag_bits", 64'(wanted.flags), 64'(got.flags));
            check_field("pcr_base", 64'(wanted.pcr_base), 64'(got.pcr_base));
            check_field("pcr_extension", 64'(wanted.pcr_xtn), 64'(got.pcr_xtn));
            check_field("pcr_full", 64'(wanted.pcr_full), 64'(got.pcr_full));
            check_field("opcr_base", 64'(wanted.opcr_base), 64'(got.opcr_base));
            check_field("opcr_extension", 64'(wanted.opcr_xtn), 64'(got.opcr_xtn));
            check_field("opcr_full", 64'(wanted.opcr_full), 64'(got.opcr_full));
            check_field("chosen_time", 64'(wanted.chosen), 64'(got.chosen));
            check_field("splice_countdown", 64'(wanted.splice), 64'(got.splice));
         end
      end
   end

   // watchdog: ends the run if no item moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // result side: a random wait before each item, plus one long hold-off on request
   initial begin : result_sink
      int unsigned wait_cycles;
      forever begin
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
         end
         wait_cycles = rsp_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // offer one byte after a random gap and hold it until it is taken;
   // valid stays high across back-to-back items
   task automatic send_byte(input logic [7:0] b, input bit start, input bit bend);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      req_tlast  <= bend;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // directed tests
   // ------------------------------------------------------------------

   // bytes outside a field are dropped, buffer end among them
   task automatic test_ignored_bytes();
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
   endtask

   // zero length has no flags byte: the result comes on the length byte
   task automatic test_zero_length();
      send_byte(8'h00, 1'b1, 1'b1);
   endtask

   // the buffer runs out on the length byte of a non-empty field
   task automatic test_buffer_end_on_length();
      send_byte(8'h05, 1'b1, 1'b1);
   endtask

   // every flag set, pcr at its maximum, opcr zero, buffer ending on the last byte
   task automatic test_complete_field();
      send_byte(8'd14, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      repeat (CLOCK_BYTES) send_byte(8'hFF, 1'b0, 1'b0);
      repeat (CLOCK_BYTES) send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
   endtask

   // pcr flagged but the declared length stops it after two of its bytes
   task automatic test_flag_overrun();
      send_byte(8'd3, 1'b1, 1'b0);
      send_byte(8'h10, 1'b0, 1'b0);
      send_byte(8'hA5, 1'b0, 1'b0);
      send_byte(8'h5A, 1'b0, 1'b0);
   endtask

   // a new length byte drops the unfinished field without a result
   task automatic test_restart_mid_field();
      send_byte(8'd4, 1'b1, 1'b0);
      send_byte(8'h10, 1'b0, 1'b0);
      send_byte(8'h3C, 1'b0, 1'b0);
      send_byte(8'h00, 1'b1, 1'b0);
   endtask

   // receiver holds off while empty fields keep coming, so the input must stall
   task automatic test_output_backpressure();
      rsp_hold_request = 1'b1;
      repeat (40) send_byte(8'h00, 1'b1, 1'($urandom_range(0, 1)));
   endtask

   // ------------------------------------------------------------------
   // random fields: mostly well formed with random content, some cut short,
   // some abandoned by a new length byte, some longer than their flags need
   // ------------------------------------------------------------------
   task automatic test_random_fields(input int unsigned budget);
      int unsigned sent;
      int unsigned need;
      int unsigned len;
      int unsigned stop;
      int unsigned kind;
      int unsigned ending;
      int unsigned pos;
      logic [7:0]  flags;
      logic [7:0]  b;
      bit          zero_pcr;
      bit          bend_last;
      bit          bend;
      sent = 0;
      while (sent < budget) begin
         // stray bytes between fields, not counted
         if ($urandom_range(0, 19) == 0)
            send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
         flags = 8'($urandom);
         need  = 1 + (flags[FLAG_PCR_BIT] ? CLOCK_BYTES : 0)
                   + (flags[FLAG_OPCR_BIT] ? CLOCK_BYTES : 0) + (flags[FLAG_SPLICE_BIT] ? 1 : 0);
         kind = $urandom_range(0, 99);
         if (kind < 3) len = 0;
         else if (kind < 5) len = $urandom_range(need + 1, 255);
         else if (kind < 17) len = $urandom_range(1, need);
         else len = need + $urandom_range(0, 3);
         zero_pcr  = ($urandom_range(0, 4) == 0);
         bend_last = ($urandom_range(0, 1) == 1);
         // 0: buffer ends early, 1: abandoned by the next field, else runs to the end
         ending = (len == 0) ? 2 : $urandom_range(0, 9);
         stop   = (ending < 2) ? $urandom_range(0, len - 1) : len;
         send_byte(8'(len), 1'b1, ending == 0 && stop == 0);
         for (pos = 1; pos <= stop; pos++) begin
            if (pos == 1) b = flags;
            else if (zero_pcr && pos < PCR_FIRST + CLOCK_BYTES) b = 8'h00;
            else b = 8'($urandom);
            bend = (ending == 0 && pos == stop) || (ending >= 2 && pos == len && bend_last);
            send_byte(b, 1'b0, bend);
         end
         sent += 1 + stop;
      end
   endtask

   // ------------------------------------------------------------------
   // run sequence
   // ------------------------------------------------------------------
   initial begin
      req_idle_on      = 1'b1;
      rsp_idle_on      = 1'b1;
      rsp_hold_request = 1'b0;
      mismatches       = 0;
      stuck_cycles     = 0;
      pa_active        = 1'b0;
      pa_pos           = '0;
      pa_len           = '0;
      pa_flags         = '0;
      pa_pcr           = '0;
      pa_opcr          = '0;
      pa_splice        = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_ignored_bytes();
      test_zero_length();
      test_buffer_end_on_length();
      test_complete_field();
      test_flag_overrun();
      test_restart_mid_field();

      // back to back on the input for the pressure test
      req_idle_on = 1'b0;
      test_output_backpressure();

      req_idle_on = 1'b1;
      test_random_fields(850);

      // a stretch with no idling on either side
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_random_fields(780);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_fields.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
